// ===== src/bbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bbpa_pkg
// Shared types, constants and helper functions for the bitmap block pool
// allocator: sizes, command and status codes, configuration struct.
// ----------------------------------------------------------------------------
package bbpa_pkg;

    // Pool geometry
    localparam int MAX_BLOCKS      = 16;
    localparam int MAX_BLOCK_BYTES = 64;
    localparam int POOL_SPAN_BYTES = 1024;

    // Fixed field widths
    localparam int CFG_BYTES_W  = 7;
    localparam int CFG_COUNT_W  = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int OFFSET_IN_W  = 12;
    localparam int STATUS_W     = 3;
    localparam int OFFSET_OUT_W = 10;
    localparam int FREE_CNT_W   = 5;
    localparam int TOTAL_W      = 32;

    // Derived internal widths
    localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int BYTES_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int DIV_W   = OFFSET_IN_W - 1;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int PROD_W  = IDX_W + BYTES_W;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [CFG_BYTES_W-1:0] RESET_BLOCK_BYTES   = CFG_BYTES_W'(64);
    localparam logic [CFG_COUNT_W-1:0] RESET_BLOCKS_IN_USE = CFG_COUNT_W'(16);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLOCK_BYTES   = 2'd0,
        CFG_BLOCKS_IN_USE = 2'd1
    } cfg_index_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC_OK    = 3'd0,
        ST_POOL_FULL   = 3'd1,
        ST_FREE_OK     = 3'd2,
        ST_BAD_ADDR    = 3'd3,
        ST_INDEX_RANGE = 3'd4,
        ST_DOUBLE_FREE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_BAD_ADDR,
        CMD_INDEX_RANGE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   idx;
    } cmd_t;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
    } pool_cfg_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } fe_state_t;

    // Effective block size: zero acts as one, large values saturate
    function automatic logic [BYTES_W-1:0] eff_bytes(input logic [CFG_BYTES_W-1:0] raw);
        logic [BYTES_W-1:0] res;
        if (raw == '0)
            res = BYTES_W'(1);
        else if (32'(raw) > 32'(MAX_BLOCK_BYTES))
            res = BYTES_W'(MAX_BLOCK_BYTES);
        else
            res = BYTES_W'(raw);
        return res;
    endfunction

    // Effective block count: zero acts as one, large values saturate
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_COUNT_W-1:0] raw);
        logic [CNT_W-1:0] res;
        if (raw == '0)
            res = CNT_W'(1);
        else if (32'(raw) > 32'(MAX_BLOCKS))
            res = CNT_W'(MAX_BLOCKS);
        else
            res = CNT_W'(raw);
        return res;
    endfunction

endpackage

// ===== src/bbpa_req_if.sv =====
// ----------------------------------------------------------------------------
// bbpa_req_if
// Request channel: operation code and signed byte offset for a free.
// ----------------------------------------------------------------------------
interface bbpa_req_if
    import bbpa_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [OFFSET_IN_W-1:0] free_offset;

    modport source (output valid, output operation, output free_offset, input ready);
    modport sink   (input valid, input operation, input free_offset, output ready);
endinterface

// ===== src/bbpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bbpa_rsp_if
// Response channel: status, allocated offset, free count and totals.
// ----------------------------------------------------------------------------
interface bbpa_rsp_if
    import bbpa_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [OFFSET_OUT_W-1:0] block_offset;
    logic [FREE_CNT_W-1:0]   free_count_out;
    logic [TOTAL_W-1:0]      alloc_total;
    logic [TOTAL_W-1:0]      free_total;
    logic [TOTAL_W-1:0]      fail_total;

    modport source (output valid, output status, output block_offset,
                    output free_count_out, output alloc_total, output free_total,
                    output fail_total, input ready);
    modport sink   (input valid, input status, input block_offset,
                    input free_count_out, input alloc_total, input free_total,
                    input fail_total, output ready);
endinterface

// ===== src/bbpa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bbpa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bbpa_cfg_if
    import bbpa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/bitmap_block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_pool_allocator_core
// Fixed-size block pool allocator with one used bit per block.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per request: operation 0 allocates the
//   lowest free block, operation 1 frees the block at free_offset.
//   rsp returns exactly one transaction per request, in order, with status,
//   allocated offset, free count and the three wrapping event totals.
//   cfg writes block_bytes (index 0) or blocks_in_use (index 1); any write
//   to either clears the pool and the totals. cfg is always ready; write it
//   only while no request is in flight.
// Timing:
//   An allocate or a rejected offset is queued without division; a free in
//   range first runs through the bit-serial divider, one quotient bit per
//   cycle over 11 offset bits. The front handles one request at a time and
//   takes no new request until the last command has been queued.
//   A two-entry command queue and the result register let the front keep
//   accepting while rsp is stalled, until the queue fills.
// Reset: block size 64, 16 blocks, all blocks free, totals zero.
// ----------------------------------------------------------------------------
module bitmap_block_pool_allocator_core
    import bbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bbpa_cfg_if.sink    cfg,
    bbpa_req_if.sink    req,
    bbpa_rsp_if.source  rsp
);

    pool_cfg_t pool_cfg_reg, pool_cfg_next;
    logic      init_reg, init_next;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    cmd_t      push_cmd;
    cmd_t      head_cmd;

    assign cfg.ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        pool_cfg_next = pool_cfg_reg;
        init_next     = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BLOCK_BYTES:
                begin
                    pool_cfg_next.bytes = eff_bytes(CFG_BYTES_W'(cfg.data));
                    init_next           = 1'b1;
                end
                CFG_BLOCKS_IN_USE:
                begin
                    pool_cfg_next.count = eff_count(CFG_COUNT_W'(cfg.data));
                    init_next           = 1'b1;
                end
                default:
                begin
                    init_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_cfg_reg.bytes <= eff_bytes(RESET_BLOCK_BYTES);
            pool_cfg_reg.count <= eff_count(RESET_BLOCKS_IN_USE);
            init_reg           <= 1'b0;
        end
        else
        begin
            pool_cfg_reg <= pool_cfg_next;
            init_reg     <= init_next;
        end
    end

    bbpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .pool_cfg (pool_cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    bbpa_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    bbpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_cfg  (pool_cfg_reg),
        .pool_init (init_reg),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .rsp       (rsp)
    );

endmodule

// ===== src/bbpa_front.sv =====
// ----------------------------------------------------------------------------
// bbpa_front
// Accepts requests, range-checks free offsets and turns them into a block
// index with a bit-serial restoring divider, then queues a command.
// ----------------------------------------------------------------------------
module bbpa_front
    import bbpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bbpa_req_if.sink   req,
    input  pool_cfg_t  pool_cfg,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    fe_state_t           state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [BYTES_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;

    logic [BYTES_W:0]    rem_shift;
    logic                qbit;
    logic                bad_addr;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    // Offset outside the pool span
    assign bad_addr = req.free_offset[OFFSET_IN_W-1] ||
                      (32'(req.free_offset[DIV_W-1:0]) >= 32'(POOL_SPAN_BYTES));

    // One quotient bit per step
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign qbit      = (rem_shift >= {1'b0, pool_cfg.bytes});

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        req.ready  = 1'b0;
        q_push     = 1'b0;
        q_cmd      = cmd_reg;

        unique case (state_reg)
            FE_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (req.operation == OP_ALLOC)
                    begin
                        cmd_next.kind = CMD_ALLOC;
                        cmd_next.idx  = '0;
                        state_next    = FE_PUSH;
                    end
                    else if (bad_addr)
                    begin
                        cmd_next.kind = CMD_BAD_ADDR;
                        cmd_next.idx  = '0;
                        state_next    = FE_PUSH;
                    end
                    else
                    begin
                        quo_next   = req.free_offset[DIV_W-1:0];
                        rem_next   = '0;
                        cnt_next   = DCNT_W'(DIV_W);
                        state_next = FE_DIV;
                    end
                end
            end

            FE_DIV:
            begin
                if (qbit)
                    rem_next = BYTES_W'(rem_shift - {1'b0, pool_cfg.bytes});
                else
                    rem_next = BYTES_W'(rem_shift);
                quo_next = {quo_reg[DIV_W-2:0], qbit};
                cnt_next = cnt_reg - DCNT_W'(1);
                // Classify the finished index
                if (cnt_reg == DCNT_W'(1))
                begin
                    if (32'(quo_next) >= 32'(pool_cfg.count))
                        cmd_next.kind = CMD_INDEX_RANGE;
                    else
                        cmd_next.kind = CMD_FREE;
                    cmd_next.idx = IDX_W'(quo_next);
                    state_next   = FE_PUSH;
                end
            end

            FE_PUSH:
            begin
                q_push = 1'b1;
                if (!q_full)
                    state_next = FE_IDLE;
            end

            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bbpa_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// bbpa_cmd_queue
// Short register FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module bbpa_cmd_queue
    import bbpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            if (32'(wr_ptr_reg) == 32'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            if (32'(rd_ptr_reg) == 32'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== src/bbpa_back.sv =====
// ----------------------------------------------------------------------------
// bbpa_back
// Executes queued commands against the used map, keeps the free count and
// event counters, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bbpa_back
    import bbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pool_cfg_t   pool_cfg,
    input  logic        pool_init,
    input  cmd_t        head_cmd,
    input  logic        q_empty,
    output logic        q_pop,
    bbpa_rsp_if.source  rsp
);

    logic [MAX_BLOCKS-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]        free_blocks_reg, free_blocks_next;
    logic [TOTAL_W-1:0]      alloc_cnt_reg, alloc_cnt_next;
    logic [TOTAL_W-1:0]      free_cnt_reg, free_cnt_next;
    logic [TOTAL_W-1:0]      fail_cnt_reg, fail_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic [OFFSET_OUT_W-1:0] offset_reg, offset_next;

    logic                    found;
    logic [IDX_W-1:0]        hit_idx;
    logic [PROD_W-1:0]       prod;

    assign q_pop = !q_empty && (!out_valid_reg || rsp.ready);

    // Lowest free block below the configured count
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            if (!found && (32'(i) < 32'(pool_cfg.count)) && !used_reg[i])
            begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign prod = PROD_W'(hit_idx) * PROD_W'(pool_cfg.bytes);

    // Execute one command
    always_comb
    begin
        used_next        = used_reg;
        free_blocks_next = free_blocks_reg;
        alloc_cnt_next   = alloc_cnt_reg;
        free_cnt_next    = free_cnt_reg;
        fail_cnt_next    = fail_cnt_reg;
        status_next      = status_reg;
        offset_next      = offset_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;

        if (pool_init)
        begin
            used_next        = '0;
            free_blocks_next = pool_cfg.count;
            alloc_cnt_next   = '0;
            free_cnt_next    = '0;
            fail_cnt_next    = '0;
        end
        else if (q_pop)
        begin
            out_valid_next = 1'b1;
            offset_next    = '0;
            case (head_cmd.kind)
                CMD_ALLOC:
                begin
                    if (found)
                    begin
                        used_next[hit_idx] = 1'b1;
                        free_blocks_next   = free_blocks_reg - CNT_W'(1);
                        alloc_cnt_next     = alloc_cnt_reg + TOTAL_W'(1);
                        offset_next        = OFFSET_OUT_W'(prod);
                        status_next        = ST_ALLOC_OK;
                    end
                    else
                    begin
                        fail_cnt_next = fail_cnt_reg + TOTAL_W'(1);
                        status_next   = ST_POOL_FULL;
                    end
                end
                CMD_FREE:
                begin
                    if (used_reg[head_cmd.idx])
                    begin
                        used_next[head_cmd.idx] = 1'b0;
                        free_blocks_next        = free_blocks_reg + CNT_W'(1);
                        free_cnt_next           = free_cnt_reg + TOTAL_W'(1);
                        status_next             = ST_FREE_OK;
                    end
                    else
                    begin
                        status_next = ST_DOUBLE_FREE;
                    end
                end
                CMD_BAD_ADDR:
                begin
                    status_next = ST_BAD_ADDR;
                end
                default:
                begin
                    status_next = ST_INDEX_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            free_blocks_reg <= eff_count(RESET_BLOCKS_IN_USE);
            alloc_cnt_reg   <= '0;
            free_cnt_reg    <= '0;
            fail_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            used_reg        <= used_next;
            free_blocks_reg <= free_blocks_next;
            alloc_cnt_reg   <= alloc_cnt_next;
            free_cnt_reg    <= free_cnt_next;
            fail_cnt_reg    <= fail_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        offset_reg <= offset_next;
    end

    // Drive the response; state only moves when a new result is loaded or the pool is reinitialized
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.block_offset   = offset_reg;
    assign rsp.free_count_out = FREE_CNT_W'(free_blocks_reg);
    assign rsp.alloc_total    = alloc_cnt_reg;
    assign rsp.free_total     = free_cnt_reg;
    assign rsp.fail_total     = fail_cnt_reg;

endmodule

// ===== tb/sv/tb_bitmap_block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_block_pool_allocator_core
// Self-checking bench for the block pool allocator. A shadow copy of the used
// bitmap, free count and event totals predicts every reply. Stimulus is a
// directed prologue followed by randomized phases under varied pool settings.
// Both handshake sides idle at random. Two long reply stalls back up the
// request side.
// ----------------------------------------------------------------------------
module tb_bitmap_block_pool_allocator_core;
    import bbpa_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 40;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES    = 9;
    localparam int PHASE_ITEMS      = 100;

    // Register indexes past the end of the map
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        STEP_REQUEST,
        STEP_REG_WRITE,
        STEP_DRAIN,
        STEP_HOLD_SINK
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t                    kind;
        op_t                           op;
        logic signed [OFFSET_IN_W-1:0] offset;
        logic [CFG_INDEX_W-1:0]        reg_index;
        logic [CFG_DATA_W-1:0]         reg_data;
    } plan_step_t;

    typedef struct packed {
        status_t                 status;
        logic [OFFSET_OUT_W-1:0] block_offset;
        logic [FREE_CNT_W-1:0]   free_count;
        logic [TOTAL_W-1:0]      alloc_total;
        logic [TOTAL_W-1:0]      free_total;
        logic [TOTAL_W-1:0]      fail_total;
    } pool_reply_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side drivers of the block inputs
    logic                          drv_req_valid  = 1'b0;
    op_t                           drv_req_op     = OP_ALLOC;
    logic signed [OFFSET_IN_W-1:0] drv_req_offset = '0;
    logic                          drv_cfg_valid  = 1'b0;
    logic [CFG_INDEX_W-1:0]        drv_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]         drv_cfg_data   = '0;
    logic                          mon_rsp_ready  = 1'b0;

    bbpa_cfg_if cfg_bus();
    bbpa_req_if req_bus();
    bbpa_rsp_if rsp_bus();

    assign req_bus.valid       = drv_req_valid;
    assign req_bus.operation   = drv_req_op;
    assign req_bus.free_offset = drv_req_offset;
    assign cfg_bus.valid       = drv_cfg_valid;
    assign cfg_bus.index       = drv_cfg_index;
    assign cfg_bus.data        = drv_cfg_data;
    assign rsp_bus.ready       = mon_rsp_ready;

    bitmap_block_pool_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow pool state
    logic [CFG_BYTES_W-1:0] shadow_size_raw;
    logic [CFG_COUNT_W-1:0] shadow_count_raw;
    logic [MAX_BLOCKS-1:0]  shadow_used;
    int                     shadow_free;
    logic [TOTAL_W-1:0]     shadow_allocs;
    logic [TOTAL_W-1:0]     shadow_frees;
    logic [TOTAL_W-1:0]     shadow_fails;

    plan_step_t  request_plan[$];
    pool_reply_t predicted_replies[$];

    int          error_count = 0;
    int          cycle_count = 0;
    logic        plan_done   = 1'b0;
    int unsigned hold_token  = 0;
    int unsigned hold_seen   = 0;

    int unsigned gap_left     = 0;
    int unsigned settle_left  = 0;
    logic        drain_active = 1'b0;
    int unsigned src_calm     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    int unsigned sink_calm    = 0;

    // Generate clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Release reset
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Zero size acts as one, oversize saturates
    function automatic int block_size_of(input logic [CFG_BYTES_W-1:0] raw);
        int size;
        size = int'(raw);
        if (size == 0)
            size = 1;
        else if (size > MAX_BLOCK_BYTES)
            size = MAX_BLOCK_BYTES;
        return size;
    endfunction

    // Zero count acts as one, overcount saturates
    function automatic int block_count_of(input logic [CFG_COUNT_W-1:0] raw);
        int count;
        count = int'(raw);
        if (count == 0)
            count = 1;
        else if (count > MAX_BLOCKS)
            count = MAX_BLOCKS;
        return count;
    endfunction

    // Clear the bitmap and totals after any register change
    function automatic void reload_pool();
        shadow_used   = '0;
        shadow_free   = block_count_of(shadow_count_raw);
        shadow_allocs = '0;
        shadow_frees  = '0;
        shadow_fails  = '0;
    endfunction

    function automatic void apply_register_write(input logic [CFG_INDEX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0]  data);
        if (idx == CFG_BLOCK_BYTES) begin
            shadow_size_raw = data[CFG_BYTES_W-1:0];
            reload_pool();
        end
        else if (idx == CFG_BLOCKS_IN_USE) begin
            shadow_count_raw = data[CFG_COUNT_W-1:0];
            reload_pool();
        end
    endfunction

    // Predict the reply to one request and advance the shadow pool
    function automatic pool_reply_t predict_pool_reply(input op_t op,
                                                       input logic signed [OFFSET_IN_W-1:0] off);
        pool_reply_t res;
        int          size;
        int          count;
        int          soff;
        int          idx;
        logic        found;
        size  = block_size_of(shadow_size_raw);
        count = block_count_of(shadow_count_raw);
        res.block_offset = '0;
        if (op == OP_ALLOC) begin
            found = 1'b0;
            for (int i = 0; i < count; i++) begin
                if (!found && !shadow_used[i]) begin
                    shadow_used[i]   = 1'b1;
                    shadow_free      = shadow_free - 1;
                    shadow_allocs    = shadow_allocs + 1;
                    res.block_offset = OFFSET_OUT_W'(i * size);
                    found            = 1'b1;
                end
            end
            if (found)
                res.status = ST_ALLOC_OK;
            else begin
                shadow_fails = shadow_fails + 1;
                res.status   = ST_POOL_FULL;
            end
        end
        else begin
            soff = off;
            if (soff < 0 || soff >= POOL_SPAN_BYTES)
                res.status = ST_BAD_ADDR;
            else begin
                idx = soff / size;
                if (idx >= count)
                    res.status = ST_INDEX_RANGE;
                else if (shadow_used[idx]) begin
                    shadow_used[idx] = 1'b0;
                    shadow_free      = shadow_free + 1;
                    shadow_frees     = shadow_frees + 1;
                    res.status       = ST_FREE_OK;
                end
                else
                    res.status = ST_DOUBLE_FREE;
            end
        end
        res.free_count  = FREE_CNT_W'(shadow_free);
        res.alloc_total = shadow_allocs;
        res.free_total  = shadow_frees;
        res.fail_total  = shadow_fails;
        return res;
    endfunction

    // Idle cycles before the next transaction, with runs of back-to-back traffic
    function automatic int unsigned draw_idle(inout int unsigned calm);
        int unsigned gap;
        if (calm != 0) begin
            calm = calm - 1;
            gap  = 0;
        end
        else if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            gap  = 0;
        end
        else
            gap = $urandom_range(0, 14);
        return gap;
    endfunction

    // Drive requests and register writes from the plan
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        plan_step_t step;
        logic       offer_req;
        logic       offer_cfg;
        if (!rst_n) begin
            drv_req_valid    <= 1'b0;
            drv_cfg_valid    <= 1'b0;
            gap_left         = 0;
            settle_left      = 0;
            drain_active     = 1'b0;
            shadow_size_raw  = RESET_BLOCK_BYTES;
            shadow_count_raw = RESET_BLOCKS_IN_USE;
            reload_pool();
        end
        else begin
            offer_req = drv_req_valid;
            offer_cfg = drv_cfg_valid;
            // Retire accepted transactions
            if (drv_req_valid && req_bus.ready) begin
                predicted_replies.push_back(predict_pool_reply(drv_req_op, drv_req_offset));
                offer_req = 1'b0;
            end
            if (drv_cfg_valid && cfg_bus.ready) begin
                apply_register_write(drv_cfg_index, drv_cfg_data);
                offer_cfg = 1'b0;
            end
            // Advance to the next plan step once both channels are free
            if (!offer_req && !offer_cfg) begin
                if (gap_left != 0)
                    gap_left = gap_left - 1;
                else if (drain_active) begin
                    if (predicted_replies.size() == 0) begin
                        if (settle_left == 0)
                            drain_active = 1'b0;
                        else
                            settle_left = settle_left - 1;
                    end
                end
                else if (request_plan.size() != 0) begin
                    step = request_plan.pop_front();
                    case (step.kind)
                        STEP_REQUEST:
                        begin
                            offer_req      = 1'b1;
                            drv_req_op     <= step.op;
                            drv_req_offset <= step.offset;
                            gap_left       = draw_idle(src_calm);
                        end
                        STEP_REG_WRITE:
                        begin
                            offer_cfg     = 1'b1;
                            drv_cfg_index <= step.reg_index;
                            drv_cfg_data  <= step.reg_data;
                        end
                        STEP_DRAIN:
                        begin
                            drain_active = 1'b1;
                            settle_left  = SETTLE_CYCLES;
                        end
                        STEP_HOLD_SINK:
                            hold_token <= hold_token + 1;
                        default: ;
                    endcase
                end
                else
                    plan_done <= 1'b1;
            end
            drv_req_valid <= offer_req;
            drv_cfg_valid <= offer_cfg;
        end
    end

    // Check replies against the predicted queue and throttle ready
    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        pool_reply_t want;
        if (!rst_n) begin
            mon_rsp_ready <= 1'b0;
            stall_left    = 0;
            hold_left     = 0;
            hold_seen     = 0;
        end
        else begin
            if (rsp_bus.valid && mon_rsp_ready) begin
                if (predicted_replies.size() == 0) begin
                    $error("reply with none pending: status %0d", rsp_bus.status);
                    error_count++;
                end
                else begin
                    want = predicted_replies.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                        error_count++;
                    end
                    if (rsp_bus.block_offset !== want.block_offset) begin
                        $error("block_offset: expected %0d, actual %0d",
                               want.block_offset, rsp_bus.block_offset);
                        error_count++;
                    end
                    if (rsp_bus.free_count_out !== want.free_count) begin
                        $error("free_count_out: expected %0d, actual %0d",
                               want.free_count, rsp_bus.free_count_out);
                        error_count++;
                    end
                    if (rsp_bus.alloc_total !== want.alloc_total) begin
                        $error("alloc_total: expected %0d, actual %0d",
                               want.alloc_total, rsp_bus.alloc_total);
                        error_count++;
                    end
                    if (rsp_bus.free_total !== want.free_total) begin
                        $error("free_total: expected %0d, actual %0d",
                               want.free_total, rsp_bus.free_total);
                        error_count++;
                    end
                    if (rsp_bus.fail_total !== want.fail_total) begin
                        $error("fail_total: expected %0d, actual %0d",
                               want.fail_total, rsp_bus.fail_total);
                        error_count++;
                    end
                end
                stall_left = draw_idle(sink_calm);
            end
            // Start a long stall when the plan asks for one
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = SINK_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left     = hold_left - 1;
                mon_rsp_ready <= 1'b0;
            end
            else if (stall_left != 0) begin
                stall_left    = stall_left - 1;
                mon_rsp_ready <= 1'b0;
            end
            else
                mon_rsp_ready <= 1'b1;
        end
    end

    // Planned register values, tracked to shape the free offsets
    logic [CFG_BYTES_W-1:0] plan_size_raw  = RESET_BLOCK_BYTES;
    logic [CFG_COUNT_W-1:0] plan_count_raw = RESET_BLOCKS_IN_USE;

    task automatic plan_request(input op_t op, input logic signed [OFFSET_IN_W-1:0] off);
        plan_step_t step;
        step           = '0;
        step.kind      = STEP_REQUEST;
        step.op        = op;
        step.offset    = off;
        request_plan.push_back(step);
    endtask

    task automatic plan_marker(input plan_kind_t kind);
        plan_step_t step;
        step      = '0;
        step.kind = kind;
        request_plan.push_back(step);
    endtask

    // Register writes only land on an idle block
    task automatic plan_register(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0]  data);
        plan_step_t step;
        step           = '0;
        step.kind      = STEP_REG_WRITE;
        step.reg_index = idx;
        step.reg_data  = data;
        plan_marker(STEP_DRAIN);
        request_plan.push_back(step);
        if (idx == CFG_BLOCK_BYTES)
            plan_size_raw = data[CFG_BYTES_W-1:0];
        else if (idx == CFG_BLOCKS_IN_USE)
            plan_count_raw = data[CFG_COUNT_W-1:0];
    endtask

    // Build the stimulus plan
    initial
    begin : stimulus_plan
        logic [CFG_DATA_W-1:0] size_data;
        logic [CFG_DATA_W-1:0] count_data;
        int                    alloc_bias;
        int                    size;
        int                    count;
        int                    pick;
        int                    off;

        // Default pool: address checks, fill to full, free and reuse
        plan_request(OP_FREE, OFFSET_IN_W'(0));
        plan_request(OP_FREE, OFFSET_IN_W'(-1));
        plan_request(OP_FREE, OFFSET_IN_W'(-2048));
        plan_request(OP_FREE, OFFSET_IN_W'(1024));
        plan_request(OP_FREE, OFFSET_IN_W'(2047));
        for (int i = 0; i < MAX_BLOCKS; i++)
            plan_request(OP_ALLOC, OFFSET_IN_W'($urandom));
        plan_request(OP_ALLOC, OFFSET_IN_W'(-1));
        plan_request(OP_FREE, OFFSET_IN_W'(1023));
        plan_request(OP_FREE, OFFSET_IN_W'(197));
        plan_request(OP_ALLOC, OFFSET_IN_W'(0));

        // Zero size and zero count: index range, single-block pool
        plan_register(CFG_BLOCK_BYTES, 7'd0);
        plan_register(CFG_BLOCKS_IN_USE, 7'd0);
        plan_request(OP_FREE, OFFSET_IN_W'(1));
        plan_request(OP_ALLOC, OFFSET_IN_W'(0));
        plan_request(OP_ALLOC, OFFSET_IN_W'(0));
        // Writes past the register map leave the pool alone
        plan_register(CFG_SPARE_A, 7'h7F);
        plan_register(CFG_SPARE_B, 7'h55);
        plan_request(OP_FREE, OFFSET_IN_W'(0));
        plan_request(OP_FREE, OFFSET_IN_W'(0));

        // Random phases under varied settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin size_data = 7'd1;   count_data = 7'd31;  end
                1: begin size_data = 7'd127; count_data = 7'd1;   end
                2: begin size_data = 7'd64;  count_data = 7'h7F;  end
                3: begin size_data = 7'd65;  count_data = 7'd16;  end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       size_data = 7'd1;
                        1:       size_data = 7'd64;
                        default: size_data = CFG_DATA_W'($urandom_range(0, 127));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       count_data = 7'd16;
                        1:       count_data = CFG_DATA_W'($urandom_range(0, 127));
                        default: count_data = CFG_DATA_W'($urandom_range(1, 16));
                    endcase
                end
            endcase
            if ($urandom_range(0, 1) == 0) begin
                plan_register(CFG_BLOCK_BYTES, size_data);
                plan_register(CFG_BLOCKS_IN_USE, count_data);
            end
            else begin
                plan_register(CFG_BLOCKS_IN_USE, count_data);
                plan_register(CFG_BLOCK_BYTES, size_data);
            end
            size       = block_size_of(plan_size_raw);
            count      = block_count_of(plan_count_raw);
            alloc_bias = $urandom_range(30, 70);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back up the block behind a long reply stall
                if ((ph == 3 || ph == 6) && n == 10)
                    plan_marker(STEP_HOLD_SINK);
                // Let every reply come home mid-phase
                if (ph == 5 && n == 50)
                    plan_marker(STEP_DRAIN);
                pick = $urandom_range(0, 99);
                if (pick < alloc_bias)
                    plan_request(OP_ALLOC, OFFSET_IN_W'($urandom));
                else if (pick < alloc_bias + (100 - alloc_bias) * 7 / 10) begin
                    off = $urandom_range(0, count - 1) * size + $urandom_range(0, size - 1);
                    plan_request(OP_FREE, OFFSET_IN_W'(off));
                end
                else if (pick < alloc_bias + (100 - alloc_bias) * 85 / 100)
                    plan_request(OP_FREE, OFFSET_IN_W'($urandom_range(0, POOL_SPAN_BYTES - 1)));
                else
                    plan_request(OP_FREE, OFFSET_IN_W'($urandom));
            end
        end
    end

    // End of run: wait out the plan and the pending replies
    initial
    begin : run_control
        while (!plan_done)
            @(posedge clk);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
